>>> hw/rtl/dba_pkg.sv
package dba_pkg;

   localparam int MAX_BLOCKS_DEF = 64;

   localparam logic [15:0] ARENA_START_RST = 16'h0100;
   localparam logic [15:0] ARENA_TOP_RST   = 16'h9FFF;
   localparam logic [15:0] LOADFIX_OWNER   = 16'h0040;
   localparam logic [15:0] LARGEST_MODE    = 16'hFFFF;

   // request codes
   localparam logic [2:0] FUNC_ALLOC      = 3'd0;
   localparam logic [2:0] FUNC_FREE       = 3'd1;
   localparam logic [2:0] FUNC_RESIZE     = 3'd2;
   localparam logic [2:0] FUNC_QUERY      = 3'd3;
   localparam logic [2:0] FUNC_FREE_OWNER = 3'd4;
   localparam logic [2:0] FUNC_REINIT     = 3'd5;

   // result codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BAD  = 2'd1;
   localparam logic [1:0] ST_OOM  = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   // fit strategies
   localparam logic [2:0] KIND_FIRST   = 3'd0;
   localparam logic [2:0] KIND_BEST    = 3'd1;
   localparam logic [2:0] KIND_LAST    = 3'd2;
   localparam logic [2:0] KIND_OTHER   = 3'd3;
   localparam logic [2:0] KIND_LARGEST = 3'd4;

   // register indexes
   localparam logic CSR_ARENA_START = 1'b0;
   localparam logic CSR_ARENA_TOP   = 1'b1;

   typedef struct packed {
      logic [15:0] owner;
      logic [15:0] size;
   } entry_type;

   function automatic logic [2:0] decode_kind(input logic [15:0] m);
      logic [2:0] k;
      k = KIND_OTHER;
      if (m == LARGEST_MODE) begin
         k = KIND_LARGEST;
      end else if ((m[15:6] == 10'd0 || m[15:6] == 10'd1 || m[15:6] == 10'd2)
                   && m[5:0] <= 6'd2) begin
         k = {1'b0, m[1:0]};
      end
      return k;
   endfunction

endpackage

>>> hw/rtl/dba_ram.sv
module dba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> hw/rtl/dos_block_allocator.sv
// Paragraph block allocator. One request beat on req_* (func, size, fit mode,
// segment, owner) gives exactly one result beat on rsp_* (status, block
// segment, available size). Both channels are valid/ready.
// The block table lives in one RAM of {owner, size} entries; header segments
// are rebuilt on the fly from the arena base, since blocks are contiguous.
// Each valid request but re-init streams the table once through a single
// read/merge/write unit; alloc and query compact runs of free blocks as they go.
// An alloc that splits a block then shifts the entries above the chosen one
// up by one and writes the two halves.
// One request is in flight at a time; req_ready is high while idle, even
// when an earlier result is still waiting on rsp_ready. A stalled receiver
// holds the finished result and the block waits before posting the next.
// After reset the block writes the first table entry (S_INIT) and then
// takes requests. csr_* writes of arena start and top take effect at the
// next re-init request; reset restores the default values.
module dos_block_allocator #(
   parameter int MAX_BLOCKS = dba_pkg::MAX_BLOCKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_req_size,
   input  logic [15:0] req_fit_mode,
   input  logic [15:0] req_segment,
   input  logic [15:0] req_owner,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_block_segment,
   output logic [15:0] rsp_avail_size,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   import dba_pkg::*;

   localparam int AW  = $clog2(MAX_BLOCKS);
   localparam int CW  = $clog2(MAX_BLOCKS + 1);
   localparam int CW1 = CW + 1;
   localparam logic [CW-1:0] MAX_C  = CW'(MAX_BLOCKS);
   localparam logic [CW:0]   MAX_C1 = CW1'(MAX_BLOCKS);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_RD, S_PROC, S_FIN, S_TAIL, S_POST,
      S_SH_RD, S_SH_WR, S_SPLIT1, S_SPLIT2, S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [15:0]   astart_ff, atop_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [15:0]   base_ff, base_in;
   logic [2:0]    func_ff, func_in, kind_ff, kind_in;
   logic [15:0]   rq_ff, rq_in, seg_ff, seg_in, own_ff, own_in;
   logic [CW-1:0] src_ff, src_in, wr_ff, wr_in, sh_ff, sh_in;
   logic [15:0]   estart_ff, estart_in;
   logic          p_vld_ff, p_vld_in, p_merge_ff, p_merge_in, p_tgt_ff, p_tgt_in;
   logic [15:0]   p_size_ff, p_size_in, p_owner_ff, p_owner_in, p_start_ff, p_start_in;
   logic [15:0]   tail_ff, tail_in;
   logic          mark_ff, mark_in;
   logic          big_vld_ff, big_vld_in;
   logic [15:0]   big_ff, big_in, big_start_ff, big_start_in;
   logic [AW-1:0] big_idx_ff, big_idx_in;
   logic          fnd_vld_ff, fnd_vld_in;
   logic [AW-1:0] fnd_idx_ff, fnd_idx_in;
   logic [15:0]   fnd_size_ff, fnd_size_in, fnd_start_ff, fnd_start_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [15:0]   res_seg_ff, res_seg_in, res_avail_ff, res_avail_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [15:0]   rsp_seg_ff, rsp_seg_in, rsp_avail_ff, rsp_avail_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   entry_type     ram_wdata, ram_q;

   logic          have_e, absorb, load_e, tail_go, a_vld, a_split, a_fail;
   logic [15:0]   wo, ws, tsz, a_size, a_start, a_rest;
   logic [AW-1:0] a_idx;
   logic [CW:0]   cur_cnt;
   logic [CW-1:0] fnd_nxt;

   dba_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_segment = rsp_seg_ff;
   assign rsp_avail_size    = rsp_avail_ff;

   // table size as it stands mid-stream: written + pending + unread
   assign cur_cnt = {1'b0, wr_ff} + CW1'(1) + {1'b0, cnt_ff} - {1'b0, src_ff};
   assign fnd_nxt = CW'(fnd_idx_ff) + CW'(1);
   assign tsz     = p_size_ff - rq_ff - 16'd1;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      base_in       = base_ff;
      func_in       = func_ff;
      kind_in       = kind_ff;
      rq_in         = rq_ff;
      seg_in        = seg_ff;
      own_in        = own_ff;
      src_in        = src_ff;
      wr_in         = wr_ff;
      sh_in         = sh_ff;
      estart_in     = estart_ff;
      p_vld_in      = p_vld_ff;
      p_merge_in    = p_merge_ff;
      p_tgt_in      = p_tgt_ff;
      p_size_in     = p_size_ff;
      p_owner_in    = p_owner_ff;
      p_start_in    = p_start_ff;
      tail_in       = tail_ff;
      mark_in       = mark_ff;
      big_vld_in    = big_vld_ff;
      big_in        = big_ff;
      big_start_in  = big_start_ff;
      big_idx_in    = big_idx_ff;
      fnd_vld_in    = fnd_vld_ff;
      fnd_idx_in    = fnd_idx_ff;
      fnd_size_in   = fnd_size_ff;
      fnd_start_in  = fnd_start_ff;
      res_status_in = res_status_ff;
      res_seg_in    = res_seg_ff;
      res_avail_in  = res_avail_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_seg_in    = rsp_seg_ff;
      rsp_avail_in  = rsp_avail_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = '0;
      have_e        = 1'b0;
      absorb        = 1'b0;
      load_e        = 1'b0;
      tail_go       = 1'b0;
      wo            = p_owner_ff;
      ws            = p_size_ff;
      a_vld         = fnd_vld_ff;
      a_idx         = fnd_idx_ff;
      a_size        = fnd_size_ff;
      a_start       = fnd_start_ff;
      a_split       = 1'b0;
      a_fail        = 1'b0;
      a_rest        = fnd_size_ff - rq_ff - 16'd1;

      case (state_ff)
         S_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '{owner: 16'd0, size: atop_ff - astart_ff - 16'd1};
            cnt_in    = CW'(1);
            base_in   = astart_ff;
            state_in  = S_IDLE;
         end

         S_IDLE: begin
            if (req_valid) begin
               func_in       = req_func;
               kind_in       = decode_kind(req_fit_mode);
               rq_in         = req_req_size;
               seg_in        = req_segment;
               own_in        = req_owner;
               src_in        = '0;
               wr_in         = '0;
               estart_in     = base_ff;
               p_vld_in      = 1'b0;
               mark_in       = 1'b0;
               big_vld_in    = 1'b0;
               big_in        = 16'd0;
               fnd_vld_in    = 1'b0;
               res_status_in = ST_OK;
               res_seg_in    = 16'd0;
               res_avail_in  = 16'd0;
               if (req_func == FUNC_REINIT) begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = '{owner: 16'd0, size: atop_ff - astart_ff - 16'd1};
                  cnt_in    = CW'(1);
                  base_in   = astart_ff;
                  state_in  = S_DONE;
               end else if (req_func > FUNC_REINIT) begin
                  res_status_in = ST_BAD;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_RD;
               end
            end
         end

         S_RD: begin
            ram_re    = 1'b1;
            ram_raddr = src_ff[AW-1:0];
            state_in  = S_PROC;
         end

         S_PROC, S_FIN: begin
            have_e = (state_ff == S_PROC);
            absorb = have_e && p_vld_ff && p_merge_ff && (ram_q.owner == 16'd0);
            load_e = have_e;
            if (absorb) begin
               load_e    = 1'b0;
               p_size_in = p_size_ff + ram_q.size + 16'd1;
            end else if (p_vld_ff) begin
               // close the pending block
               if ((func_ff == FUNC_ALLOC) && p_merge_ff) begin
                  if (!big_vld_ff || big_ff < p_size_ff) begin
                     big_vld_in   = 1'b1;
                     big_in       = p_size_ff;
                     big_idx_in   = wr_ff[AW-1:0];
                     big_start_in = p_start_ff;
                  end
                  if (p_size_ff >= rq_ff) begin
                     if (kind_ff == KIND_FIRST) begin
                        fnd_vld_in = 1'b1;
                        mark_in    = 1'b1;
                     end else if (kind_ff == KIND_BEST) begin
                        fnd_vld_in = 1'b1;
                     end else if (kind_ff != KIND_LARGEST) begin
                        fnd_vld_in = 1'b1;
                     end
                     if ((kind_ff == KIND_BEST && fnd_vld_ff && fnd_size_ff <= p_size_ff)
                         || kind_ff == KIND_LARGEST) begin
                        fnd_idx_in   = fnd_idx_ff;
                     end else begin
                        fnd_idx_in   = wr_ff[AW-1:0];
                        fnd_size_in  = p_size_ff;
                        fnd_start_in = p_start_ff;
                     end
                  end
               end
               if ((func_ff == FUNC_QUERY) && p_merge_ff && (p_size_ff > big_ff)) begin
                  big_in = p_size_ff;
               end
               if ((func_ff == FUNC_FREE_OWNER) && have_e && (own_ff != LOADFIX_OWNER)
                   && (p_owner_ff == LOADFIX_OWNER) && (ram_q.owner == own_ff)) begin
                  wo = 16'd0;
               end
               if ((func_ff == FUNC_RESIZE) && p_tgt_ff) begin
                  if (rq_ff > p_size_ff) begin
                     res_status_in = ST_OOM;
                     res_avail_in  = p_size_ff;
                  end else if (rq_ff == p_size_ff) begin
                     wo = own_ff;
                  end else if (have_e && (ram_q.owner == 16'd0)) begin
                     // tail joins the free block behind it and keeps merging
                     wo         = own_ff;
                     ws         = rq_ff;
                     load_e     = 1'b0;
                     p_size_in  = tsz + ram_q.size + 16'd1;
                     p_owner_in = 16'd0;
                     p_start_in = p_start_ff + rq_ff + 16'd1;
                     p_merge_in = 1'b1;
                     p_tgt_in   = 1'b0;
                  end else if (cur_cnt >= MAX_C1) begin
                     res_status_in = ST_FULL;
                  end else begin
                     wo      = own_ff;
                     ws      = rq_ff;
                     tail_in = tsz;
                     tail_go = 1'b1;
                  end
               end
               ram_we    = 1'b1;
               ram_waddr = wr_ff[AW-1:0];
               ram_wdata = '{owner: wo, size: ws};
               wr_in     = wr_ff + CW'(1);
            end

            if (load_e) begin
               p_vld_in   = 1'b1;
               p_size_in  = ram_q.size;
               p_owner_in = ram_q.owner;
               p_start_in = estart_ff;
               p_tgt_in   = 1'b0;
               p_merge_in = 1'b0;
               case (func_ff)
                  FUNC_ALLOC: begin
                     p_merge_in = (ram_q.owner == 16'd0) && !mark_in;
                  end
                  FUNC_QUERY: begin
                     p_merge_in = (ram_q.owner == 16'd0);
                  end
                  FUNC_RESIZE: begin
                     if (!mark_ff && (estart_ff == seg_ff - 16'd1)) begin
                        mark_in    = 1'b1;
                        p_tgt_in   = 1'b1;
                        p_merge_in = (rq_ff > ram_q.size);
                     end
                  end
                  FUNC_FREE: begin
                     if (!mark_ff && (seg_ff != 16'd0) && (estart_ff == seg_ff)) begin
                        mark_in    = 1'b1;
                        p_owner_in = 16'd0;
                     end
                  end
                  FUNC_FREE_OWNER: begin
                     if ((own_ff != LOADFIX_OWNER) && (ram_q.owner == own_ff)) begin
                        p_owner_in = 16'd0;
                     end
                  end
                  default: begin
                  end
               endcase
            end

            if (have_e) begin
               src_in    = src_ff + CW'(1);
               estart_in = estart_ff + ram_q.size + 16'd1;
               if (tail_go) begin
                  state_in = S_TAIL;
               end else if (src_ff + CW'(1) == cnt_ff) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_RD;
               end
            end else begin
               p_vld_in = 1'b0;
               state_in = tail_go ? S_TAIL : S_POST;
            end
         end

         S_TAIL: begin
            ram_we    = 1'b1;
            ram_waddr = wr_ff[AW-1:0];
            ram_wdata = '{owner: 16'd0, size: tail_ff};
            wr_in     = wr_ff + CW'(1);
            if (src_ff == cnt_ff) begin
               state_in = p_vld_ff ? S_FIN : S_POST;
            end else begin
               state_in = S_RD;
            end
         end

         S_POST: begin
            cnt_in   = wr_ff;
            state_in = S_DONE;
            case (func_ff)
               FUNC_ALLOC: begin
                  if (kind_ff == KIND_LARGEST) begin
                     a_vld   = big_vld_ff && (big_ff >= rq_ff);
                     a_idx   = big_idx_ff;
                     a_size  = big_ff;
                     a_start = big_start_ff;
                  end
                  a_fail  = !((kind_ff == KIND_FIRST) && fnd_vld_ff)
                            && (!a_vld || (a_size == 16'd0));
                  a_split = (kind_ff != KIND_LARGEST) && (rq_ff != a_size);
                  if (a_fail) begin
                     res_status_in = ST_OOM;
                     res_avail_in  = big_ff;
                  end else if (a_split && (wr_ff >= MAX_C)) begin
                     res_status_in = ST_FULL;
                  end else if (a_split) begin
                     fnd_idx_in   = a_idx;
                     fnd_size_in  = a_size;
                     fnd_start_in = a_start;
                     sh_in        = wr_ff;
                     state_in     = S_SH_RD;
                  end else begin
                     ram_we     = 1'b1;
                     ram_waddr  = a_idx;
                     ram_wdata  = '{owner: own_ff, size: a_size};
                     res_seg_in = a_start;
                     if (kind_ff == KIND_LARGEST) begin
                        res_avail_in = big_ff;
                     end
                  end
               end
               FUNC_QUERY: begin
                  res_status_in = (big_ff != 16'd0) ? ST_OK : ST_OOM;
                  res_avail_in  = big_ff;
               end
               FUNC_RESIZE, FUNC_FREE: begin
                  if (!mark_ff) begin
                     res_status_in = ST_BAD;
                  end
               end
               default: begin
               end
            endcase
         end

         S_SH_RD: begin
            if (sh_ff > fnd_nxt) begin
               ram_re    = 1'b1;
               ram_raddr = sh_in[AW-1:0] - AW'(1);
               state_in  = S_SH_WR;
            end else begin
               state_in = S_SPLIT1;
            end
         end

         S_SH_WR: begin
            ram_we    = 1'b1;
            ram_waddr = sh_ff[AW-1:0];
            ram_wdata = ram_q;
            sh_in     = sh_ff - CW'(1);
            state_in  = S_SH_RD;
         end

         S_SPLIT1: begin
            ram_we    = 1'b1;
            ram_waddr = fnd_idx_ff;
            if (kind_ff == KIND_LAST) begin
               ram_wdata  = '{owner: 16'd0, size: a_rest};
               res_seg_in = fnd_start_ff + fnd_size_ff - rq_ff;
            end else begin
               ram_wdata  = '{owner: own_ff, size: rq_ff};
               res_seg_in = fnd_start_ff;
            end
            state_in = S_SPLIT2;
         end

         S_SPLIT2: begin
            ram_we    = 1'b1;
            ram_waddr = fnd_nxt[AW-1:0];
            if (kind_ff == KIND_LAST) begin
               ram_wdata = '{owner: own_ff, size: rq_ff};
            end else begin
               ram_wdata = '{owner: 16'd0, size: a_rest};
            end
            cnt_in   = cnt_ff + CW'(1);
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_seg_in    = res_seg_ff;
               rsp_avail_in  = res_avail_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= CW'(1);
         base_ff      <= ARENA_START_RST;
         astart_ff    <= ARENA_START_RST;
         atop_ff      <= ARENA_TOP_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         base_ff      <= base_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ARENA_START: astart_ff <= csr_wdata;
               CSR_ARENA_TOP:   atop_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      func_ff       <= func_in;
      kind_ff       <= kind_in;
      rq_ff         <= rq_in;
      seg_ff        <= seg_in;
      own_ff        <= own_in;
      src_ff        <= src_in;
      wr_ff         <= wr_in;
      sh_ff         <= sh_in;
      estart_ff     <= estart_in;
      p_vld_ff      <= p_vld_in;
      p_merge_ff    <= p_merge_in;
      p_tgt_ff      <= p_tgt_in;
      p_size_ff     <= p_size_in;
      p_owner_ff    <= p_owner_in;
      p_start_ff    <= p_start_in;
      tail_ff       <= tail_in;
      mark_ff       <= mark_in;
      big_vld_ff    <= big_vld_in;
      big_ff        <= big_in;
      big_start_ff  <= big_start_in;
      big_idx_ff    <= big_idx_in;
      fnd_vld_ff    <= fnd_vld_in;
      fnd_idx_ff    <= fnd_idx_in;
      fnd_size_ff   <= fnd_size_in;
      fnd_start_ff  <= fnd_start_in;
      res_status_ff <= res_status_in;
      res_seg_ff    <= res_seg_in;
      res_avail_ff  <= res_avail_in;
      rsp_status_ff <= rsp_status_in;
      rsp_seg_ff    <= rsp_seg_in;
      rsp_avail_ff  <= rsp_avail_in;
   end

endmodule
